// ===== rtl/pbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_pkg: shared types and constants of the PackBits plane decoder
// Holds field widths, configuration register indexes, channel kinds, byte
// lanes and the structs that pass between the decoder modules.
// ----------------------------------------------------------------------------
package pbd_pkg;

    // Field widths
    localparam int DATA_W   = 8;
    localparam int PIX_W    = 23;
    localparam int ROWS_W   = 16;
    localparam int TBL_W    = ROWS_W + 1;
    localparam int KIND_W   = 3;
    localparam int IDX_W    = 22;
    localparam int CNT_W    = 8;
    localparam int LANE_W   = 2;
    localparam int CFG_IX_W = 2;
    localparam int CFG_DW   = PIX_W;

    // Largest plane that the pixel store holds
    localparam int MAX_PIXELS = 4194304;

    // PackBits header codes
    localparam logic [DATA_W-1:0] HDR_NOP = 8'd128;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_PIXEL_COUNT  = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_CHANNEL_KIND = 2'd2;

    // Channel kinds
    localparam logic [KIND_W-1:0] KIND_RED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GREEN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BLUE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OPACITY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BLACK   = 3'd4;

    // Byte lanes of a pixel word
    localparam logic [LANE_W-1:0] LANE_BLUE  = 2'd0;
    localparam logic [LANE_W-1:0] LANE_GREEN = 2'd1;
    localparam logic [LANE_W-1:0] LANE_RED   = 2'd2;
    localparam logic [LANE_W-1:0] LANE_TOP   = 2'd3;

    // Configuration register contents
    typedef struct packed {
        logic [PIX_W-1:0]  pixel_count;
        logic [ROWS_W-1:0] row_count;
        logic [KIND_W-1:0] channel_kind;
    } cfg_t;

    // One input byte held in the input register
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              start_plane;
    } in_item_t;

    // Handshake between the input register and the decode core
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } in_slot_t;

    // One write descriptor
    typedef struct packed {
        logic [IDX_W-1:0]  pixel_index;
        logic [CNT_W-1:0]  repeat_count;
        logic [LANE_W-1:0] byte_lane;
        logic [DATA_W-1:0] lane_value;
        logic              replace_lane;
        logic              write_enable;
        logic              run_clipped;
        logic              plane_done;
    } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/pbd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_in_if: compressed byte channel
// Valid/ready channel carrying one byte of the plane stream and a start mark.
// ----------------------------------------------------------------------------
interface pbd_in_if;
    import pbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              start_plane;

    modport source (output valid, output data_byte, output start_plane, input ready);
    modport sink (input valid, input data_byte, input start_plane, output ready);

endinterface
`default_nettype wire

// ===== rtl/pbd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_out_if: write descriptor channel
// Valid/ready channel carrying one pixel store write descriptor.
// ----------------------------------------------------------------------------
interface pbd_out_if;
    import pbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  pixel_index;
    logic [CNT_W-1:0]  repeat_count;
    logic [LANE_W-1:0] byte_lane;
    logic [DATA_W-1:0] lane_value;
    logic              replace_lane;
    logic              write_enable;
    logic              run_clipped;
    logic              plane_done;

    modport source (
        output valid, output pixel_index, output repeat_count, output byte_lane,
        output lane_value, output replace_lane, output write_enable,
        output run_clipped, output plane_done, input ready
    );
    modport sink (
        input valid, input pixel_index, input repeat_count, input byte_lane,
        input lane_value, input replace_lane, input write_enable,
        input run_clipped, input plane_done, output ready
    );

endinterface
`default_nettype wire

// ===== rtl/pbd_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_cfg_regs: configuration registers
// Plain write port for plane size, row count and channel kind.
// ----------------------------------------------------------------------------
module pbd_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pbd_pkg::CFG_IX_W-1:0] cfg_index,
    input  wire logic [pbd_pkg::CFG_DW-1:0]   cfg_wr_data,
    output pbd_pkg::cfg_t                     cfg
);
    import pbd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; an unused index writes nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PIXEL_COUNT:  cfg_next.pixel_count  = cfg_wr_data[PIX_W-1:0];
                CFG_ROW_COUNT:    cfg_next.row_count    = cfg_wr_data[ROWS_W-1:0];
                CFG_CHANNEL_KIND: cfg_next.channel_kind = cfg_wr_data[KIND_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_count  <= PIX_W'(1);
            cfg_reg.row_count    <= ROWS_W'(1);
            cfg_reg.channel_kind <= KIND_RED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/pbd_input_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_input_reg: input register
// Captures one byte transaction and holds it until the decode core takes it.
// ----------------------------------------------------------------------------
module pbd_input_reg (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pbd_in_if.sink        in_stream,
    input  wire logic     take,
    output pbd_pkg::in_slot_t slot
);
    import pbd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // The register is free when empty or when its byte leaves this cycle.
    assign in_stream.ready = !valid_reg || take;
    assign load            = in_stream.valid && in_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte   <= in_stream.data_byte;
            item_reg.start_plane <= in_stream.start_plane;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.item  = item_reg;

endmodule
`default_nettype wire

// ===== rtl/pbd_decode_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_decode_core: PackBits decode state and result register
// Advances the table skip and PackBits phase by one byte per cycle unless
// the output stalls; registers the descriptor of a literal or run value.
// ----------------------------------------------------------------------------
module pbd_decode_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pbd_pkg::cfg_t     cfg,
    input  wire pbd_pkg::in_slot_t slot,
    output logic                   take,
    pbd_out_if.source              out_stream
);
    import pbd_pkg::*;

    // Decode phases
    localparam logic [2:0] PH_SKIP    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_LITERAL = 3'd2;
    localparam logic [2:0] PH_RUNVAL  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [TBL_W-1:0] tbl_left_reg, tbl_left_next;
    logic [CNT_W-1:0] lit_left_reg, lit_left_next;
    logic [CNT_W-1:0] run_len_reg, run_len_next;
    logic [PIX_W-1:0] pos_reg, pos_next;

    logic             res_valid_reg, res_valid_next;
    out_item_t        res_reg;

    logic [DATA_W-1:0] byte_in;
    logic [PIX_W-1:0]  limit;
    logic [PIX_W-1:0]  pos_cur;
    logic [PIX_W-1:0]  left;
    logic [PIX_W-1:0]  want_wide;
    logic [CNT_W-1:0]  want;
    logic [CNT_W-1:0]  cnt;
    logic              emit_req;
    logic              emit_ok;
    logic              clipped;
    logic              skip_done;
    out_item_t         res_new;

    // A byte is decoded when the result register can take its outcome.
    assign take    = slot.valid && (!res_valid_reg || out_stream.ready);
    assign byte_in = slot.item.data_byte;

    // Plane limit is the configured size saturated to the store size.
    assign limit = (cfg.pixel_count > PIX_W'(MAX_PIXELS)) ? PIX_W'(MAX_PIXELS)
                                                          : cfg.pixel_count;

    // Phase update for one byte.
    always_comb
    begin
        phase_next    = phase_reg;
        tbl_left_next = tbl_left_reg;
        lit_left_next = lit_left_reg;
        run_len_next  = run_len_reg;
        pos_cur       = pos_reg;
        emit_req      = 1'b0;
        want          = CNT_W'(1);
        skip_done     = 1'b0;

        // A start mark restarts the plane; the same byte is a table byte unless the table is empty.
        if (slot.item.start_plane)
        begin
            phase_next    = PH_SKIP;
            tbl_left_next = {cfg.row_count, 1'b0};
            lit_left_next = '0;
            run_len_next  = '0;
            pos_cur       = '0;
        end

        // Skip the row byte-count table; an empty table falls through.
        if (phase_next == PH_SKIP)
        begin
            if (tbl_left_next != '0)
            begin
                tbl_left_next = tbl_left_next - TBL_W'(1);
                if (tbl_left_next == '0)
                begin
                    phase_next = PH_HEADER;
                end
                skip_done = 1'b1;
            end
            else
            begin
                phase_next = PH_HEADER;
            end
        end

        if (!skip_done)
        begin
            case (phase_next)
                PH_HEADER:
                begin
                    if (limit <= pos_cur)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (byte_in < HDR_NOP)
                    begin
                        lit_left_next = byte_in + CNT_W'(1);
                        phase_next    = PH_LITERAL;
                    end
                    else if (byte_in > HDR_NOP)
                    begin
                        run_len_next = CNT_W'(9'd257 - {1'b0, byte_in});
                        phase_next   = PH_RUNVAL;
                    end
                end
                PH_LITERAL:
                begin
                    if (lit_left_next != '0)
                    begin
                        lit_left_next = lit_left_next - CNT_W'(1);
                    end
                    if (lit_left_next == '0)
                    begin
                        phase_next = PH_HEADER;
                    end
                    emit_req = 1'b1;
                end
                PH_RUNVAL:
                begin
                    want         = run_len_next;
                    run_len_next = '0;
                    phase_next   = PH_HEADER;
                    emit_req     = 1'b1;
                end
                default:
                begin
                    emit_req = 1'b0;
                end
            endcase
        end

        // Clip the write against the plane end.
        left      = limit - pos_cur;
        want_wide = {{(PIX_W-CNT_W){1'b0}}, want};
        emit_ok   = emit_req && (pos_cur < limit);
        clipped   = want_wide > left;
        cnt       = clipped ? left[CNT_W-1:0] : want;
        pos_next  = pos_cur;

        if (emit_req && !emit_ok)
        begin
            phase_next = PH_DONE;
        end
        else if (emit_ok)
        begin
            pos_next = pos_cur + {{(PIX_W-CNT_W){1'b0}}, cnt};
            if (want_wide >= left)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    // Lane, value and mode from the channel kind.
    always_comb
    begin
        res_new.pixel_index  = pos_cur[IDX_W-1:0];
        res_new.repeat_count = cnt;
        res_new.run_clipped  = clipped;
        res_new.plane_done   = (want_wide >= left);
        res_new.byte_lane    = LANE_BLUE;
        res_new.lane_value   = byte_in;
        res_new.replace_lane = 1'b0;
        res_new.write_enable = 1'b1;
        case (cfg.channel_kind)
            KIND_RED:     res_new.byte_lane = LANE_RED;
            KIND_GREEN:   res_new.byte_lane = LANE_GREEN;
            KIND_BLUE:    res_new.byte_lane = LANE_BLUE;
            KIND_OPACITY:
            begin
                res_new.byte_lane    = LANE_TOP;
                res_new.lane_value   = ~byte_in;
                res_new.replace_lane = 1'b1;
            end
            KIND_BLACK:   res_new.byte_lane = LANE_TOP;
            default:
            begin
                res_new.lane_value   = '0;
                res_new.write_enable = 1'b0;
            end
        endcase
    end

    // Result register occupancy.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = emit_ok;
        end
        else if (out_stream.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            tbl_left_reg  <= '0;
            lit_left_reg  <= '0;
            run_len_reg   <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                phase_reg    <= phase_next;
                tbl_left_reg <= tbl_left_next;
                lit_left_reg <= lit_left_next;
                run_len_reg  <= run_len_next;
                pos_reg      <= pos_next;
            end
        end
    end

    // Descriptor payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take && emit_ok)
        begin
            res_reg <= res_new;
        end
    end

    assign out_stream.valid        = res_valid_reg;
    assign out_stream.pixel_index  = res_reg.pixel_index;
    assign out_stream.repeat_count = res_reg.repeat_count;
    assign out_stream.byte_lane    = res_reg.byte_lane;
    assign out_stream.lane_value   = res_reg.lane_value;
    assign out_stream.replace_lane = res_reg.replace_lane;
    assign out_stream.write_enable = res_reg.write_enable;
    assign out_stream.run_clipped  = res_reg.run_clipped;
    assign out_stream.plane_done   = res_reg.plane_done;

endmodule
`default_nettype wire

// ===== rtl/packbits_plane_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packbits_plane_decoder_top: PackBits plane decoder
// Turns the compressed byte stream of one image channel plane into pixel
// store write descriptors.
// ----------------------------------------------------------------------------
// The block takes one compressed byte per clock cycle while the output is
// not stalled and gives at most one write descriptor per byte, by way of
// the input and result registers. A byte with start_plane set begins a new
// plane: 2*row_count table bytes are skipped, then PackBits headers,
// literals and run values are decoded. Each literal byte or run value
// yields one descriptor; a run that passes the end of the plane is cut and
// flagged, and bytes after the plane end are dropped until the next start.
// The rate of one byte per cycle is set by the decode state update between
// the input register and the result register; either register frees
// itself in the cycle its contents move on, so both sides may stall at will.
// Write the configuration registers only while no bytes are in flight.
// ----------------------------------------------------------------------------
module packbits_plane_decoder_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pbd_pkg::CFG_IX_W-1:0] cfg_index,
    input  wire logic [pbd_pkg::CFG_DW-1:0]   cfg_wr_data,
    pbd_in_if.sink                            in_stream,
    pbd_out_if.source                         out_stream
);
    import pbd_pkg::*;

    cfg_t     cfg;
    in_slot_t slot;
    logic     take;

    // Configuration registers
    pbd_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Input register
    pbd_input_reg u_input_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .take      (take),
        .slot      (slot)
    );

    // Decode state and result register
    pbd_decode_core u_decode_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .slot       (slot),
        .take       (take),
        .out_stream (out_stream)
    );

endmodule
`default_nettype wire
